/* hw/rtl/ansi_text_console_engine_core_assert.svh */
// Assertion macros used by the console engine back end (acec_back).
`ifndef ANSI_TEXT_CONSOLE_ENGINE_CORE_ASSERT_SVH
`define ANSI_TEXT_CONSOLE_ENGINE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define ACEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ACEC_ASSERT_IMPL(lbl, ante, cons, msg) `ACEC_ASSERT(lbl, ante |-> cons, msg)
`else
`define ACEC_ASSERT(lbl, prop, msg)
`define ACEC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/acec_pkg.sv */
// Shared types, constants and a colour helper function of the console engine.
`timescale 1ns / 1ps
`default_nettype none
package acec_pkg;

  localparam int Rows        = 25;
  localparam int Cols        = 80;
  localparam int RowW        = 5;
  localparam int ColW        = 7;
  localparam int ArgW        = 14;
  localparam int ArgMax      = 9999;
  localparam int MaxArgsDef  = 8;
  localparam int QueueDepth  = 4;

  // configuration register indexes
  localparam logic RegDefAttr  = 1'b0;
  localparam logic RegTabWidth = 1'b1;

  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChEsc    = 8'h1B;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChLbrack = 8'h5B;

  localparam logic [7:0] CmdUp    = 8'h41;  // A
  localparam logic [7:0] CmdDown  = 8'h42;  // B
  localparam logic [7:0] CmdRight = 8'h43;  // C
  localparam logic [7:0] CmdLeft  = 8'h44;  // D
  localparam logic [7:0] CmdPosH  = 8'h48;  // H
  localparam logic [7:0] CmdClrJ  = 8'h4A;  // J
  localparam logic [7:0] CmdEolK  = 8'h4B;  // K
  localparam logic [7:0] CmdPosF  = 8'h66;  // f
  localparam logic [7:0] CmdSgr   = 8'h6D;  // m
  localparam logic [7:0] CmdSave  = 8'h73;  // s
  localparam logic [7:0] CmdRest  = 8'h75;  // u

  localparam logic [7:0] BrightBit = 8'h08;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_CLR_EOL = 3'd1,
    OP_SCROLL  = 3'd2,
    OP_CLR_SCR = 3'd3,
    OP_CURSOR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CL_ESC,
    CL_LF,
    CL_TAB,
    CL_DIGIT,
    CL_SEMI,
    CL_LBRACK,
    CL_OTHER
  } class_e;

  typedef struct packed {
    class_e      cls;
    logic [7:0]  code;
  } token_t;

  typedef struct packed {
    op_e              op;
    logic [RowW-1:0]  cell_row;
    logic [ColW-1:0]  cell_col;
    logic [7:0]       char_code;
    logic [7:0]       attr_out;
    logic [RowW-1:0]  cursor_row;
    logic [ColW-1:0]  cursor_col;
    logic             last;
  } result_t;

  // ANSI colour index to VGA colour index
  function automatic logic [2:0] vga_colour(input logic [2:0] idx);
    logic [2:0] c;
    unique case (idx)
      3'd0: c = 3'd0;
      3'd1: c = 3'd4;
      3'd2: c = 3'd2;
      3'd3: c = 3'd6;
      3'd4: c = 3'd1;
      3'd5: c = 3'd5;
      3'd6: c = 3'd3;
      3'd7: c = 3'd7;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/acec_stream_if.sv */
// Valid/ready stream interfaces for input bytes and screen results.
`timescale 1ns / 1ps
`default_nettype none
interface acec_in_if
  import acec_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface acec_out_if
  import acec_pkg::*;
  ();
  logic            valid;
  logic            ready;
  logic [2:0]      op;
  logic [RowW-1:0] cell_row;
  logic [ColW-1:0] cell_col;
  logic [7:0]      char_code;
  logic [7:0]      attr_out;
  logic [RowW-1:0] cursor_row;
  logic [ColW-1:0] cursor_col;
  logic            last;
  modport source (output valid, output op, output cell_row, output cell_col,
                  output char_code, output attr_out, output cursor_row,
                  output cursor_col, output last, input ready);
  modport sink (input valid, input op, input cell_row, input cell_col,
                input char_code, input attr_out, input cursor_row,
                input cursor_col, input last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/acec_front.sv */
// Front end: accepts input bytes and classifies them into tokens.
`timescale 1ns / 1ps
`default_nettype none
module acec_front
  import acec_pkg::*;
(
  acec_in_if.sink  in_i,
  input  logic     full_i,
  output logic     push_o,
  output token_t   token_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // byte classification
  always_comb begin
    token_o.code = in_i.byte_in;
    if (in_i.byte_in == ChEsc) begin
      token_o.cls = CL_ESC;
    end else if (in_i.byte_in == ChLf) begin
      token_o.cls = CL_LF;
    end else if (in_i.byte_in == ChTab) begin
      token_o.cls = CL_TAB;
    end else if (in_i.byte_in >= ChZero && in_i.byte_in <= ChNine) begin
      token_o.cls = CL_DIGIT;
    end else if (in_i.byte_in == ChSemi) begin
      token_o.cls = CL_SEMI;
    end else if (in_i.byte_in == ChLbrack) begin
      token_o.cls = CL_LBRACK;
    end else begin
      token_o.cls = CL_OTHER;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/acec_fifo.sv */
// Short token queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module acec_fifo
  import acec_pkg::*;
#(
  parameter int DEPTH = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t token_i,
  input  logic   pop_i,
  output token_t token_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  token_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign token_o = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= token_i;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/acec_back.sv */
// Back end: escape parser, cursor and attribute state, result sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "ansi_text_console_engine_core_assert.svh"
module acec_back
  import acec_pkg::*;
#(
  parameter int MAX_ARGS = MaxArgsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       empty_i,
  input  token_t     token_i,
  output logic       pop_o,
  acec_out_if.source out_o
);

  localparam int CntW = $clog2(MAX_ARGS + 2);
  localparam int IdxW = $clog2(MAX_ARGS);

  typedef enum logic [1:0] {PS_NORMAL, PS_ESC, PS_BRACKET, PS_ARG} parse_e;
  typedef enum logic [2:0] {
    ST_IDLE, ST_TMOD, ST_TAB, ST_SCR, ST_CMD, ST_CMD2, ST_SGR
  } state_e;

  state_e          state_q, state_d;
  parse_e          parse_q, parse_d;
  logic [CntW-1:0] argc_q, argc_d;
  logic [ArgW-1:0] args_q [MAX_ARGS];
  logic [RowW-1:0] cur_row_q, cur_row_d, sav_row_q, sav_row_d, row_tmp_q, row_tmp_d;
  logic [ColW-1:0] cur_col_q, cur_col_d, sav_col_q, sav_col_d;
  logic [7:0]      attr_q, attr_d, def_attr_q, sgr_a_q, sgr_a_d, cmd_q, cmd_d;
  logic [4:0]      tab_w_q, tab_n_q, tab_n_d;
  logic [3:0]      rem_q, rem_d;
  logic [2:0]      step_q, step_d;
  logic [CntW-1:0] sgr_i_q, sgr_i_d;
  result_t         out_q, emit_r;
  logic            out_valid_q, out_free, emit, pop;

  // argument store ports
  logic            wa_en, wb_en;
  logic [IdxW-1:0] wa_idx, rd_idx;
  logic [ArgW-1:0] wa_val, rd_val;

  // helpers
  logic [CntW-1:0] argc_m1, sgr_n;
  logic [4:0]      tab_eff, rem_sh;
  logic [3:0]      rem_new;
  logic [ColW:0]   col_inc;
  logic            pc_wrap, pc_scroll, nl_scroll;
  logic [RowW-1:0] pc_row;
  logic [ColW-1:0] pc_col;
  logic [17:0]     mul10;
  logic [ArgW-1:0] dig_sat, a0, v30, v40;
  logic [ArgW:0]   sum_r, sum_c;
  logic [7:0]      sgr_next;

  assign out_free = !out_valid_q || out_o.ready;
  assign pop_o    = pop;
  assign argc_m1  = argc_q - CntW'(1);
  assign sgr_n    = (argc_q > CntW'(MAX_ARGS)) ? CntW'(MAX_ARGS) : argc_q;

  // single read port on the argument store
  always_comb begin
    priority case (state_q)
      ST_SGR:  rd_idx = sgr_i_q[IdxW-1:0];
      ST_CMD2: rd_idx = IdxW'(1);
      ST_CMD:  rd_idx = '0;
      default: rd_idx = argc_m1[IdxW-1:0];
    endcase
  end
  assign rd_val = args_q[rd_idx];

  // digit accumulate with saturation
  assign mul10   = ({4'b0, rd_val} << 3) + ({4'b0, rd_val} << 1) + {14'b0, token_i.code[3:0]};
  assign dig_sat = (mul10 > 18'(ArgMax)) ? ArgW'(ArgMax) : mul10[ArgW-1:0];

  // tab width and remainder step
  assign tab_eff = (tab_w_q == 5'd0) ? 5'd1 : ((tab_w_q > 5'd16) ? 5'd16 : tab_w_q);
  assign rem_sh  = {rem_q, cur_col_q[step_q]};
  assign rem_new = (rem_sh >= tab_eff) ? 4'(rem_sh - tab_eff) : rem_sh[3:0];

  // cursor advance after a cell write
  assign col_inc   = {1'b0, cur_col_q} + (ColW+1)'(1);
  assign pc_wrap   = (col_inc >= (ColW+1)'(Cols));
  assign nl_scroll = (cur_row_q == RowW'(Rows - 1));
  assign pc_scroll = pc_wrap && nl_scroll;
  assign pc_row    = (pc_wrap && !nl_scroll) ? cur_row_q + RowW'(1) : cur_row_q;
  assign pc_col    = pc_wrap ? '0 : col_inc[ColW-1:0];

  // motion operands
  assign a0    = (argc_q != '0) ? rd_val : '0;
  assign sum_r = {{(ArgW+1-RowW){1'b0}}, cur_row_q} + {1'b0, a0};
  assign sum_c = {{(ArgW+1-ColW){1'b0}}, cur_col_q} + {1'b0, a0};

  // SGR attribute step
  assign v30 = rd_val - ArgW'(30);
  assign v40 = rd_val - ArgW'(40);
  always_comb begin
    sgr_next = sgr_a_q;
    if (rd_val == '0) begin
      sgr_next = def_attr_q;
    end else if (rd_val == ArgW'(1)) begin
      sgr_next = sgr_a_q | BrightBit;
    end else if (rd_val >= ArgW'(30) && rd_val <= ArgW'(37)) begin
      sgr_next[2:0] = vga_colour(v30[2:0]);
    end else if (rd_val >= ArgW'(40) && rd_val <= ArgW'(47)) begin
      sgr_next[6:4] = vga_colour(v40[2:0]);
    end
  end

  // sequencer next state
  always_comb begin
    state_d   = state_q;
    parse_d   = parse_q;
    argc_d    = argc_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    sav_row_d = sav_row_q;
    sav_col_d = sav_col_q;
    row_tmp_d = row_tmp_q;
    attr_d    = attr_q;
    sgr_a_d   = sgr_a_q;
    sgr_i_d   = sgr_i_q;
    cmd_d     = cmd_q;
    tab_n_d   = tab_n_q;
    rem_d     = rem_q;
    step_d    = step_q;
    pop       = 1'b0;
    emit      = 1'b0;
    emit_r    = '0;
    emit_r.op = OP_CURSOR;
    wa_en     = 1'b0;
    wb_en     = 1'b0;
    wa_idx    = '0;
    wa_val    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i && out_free) begin
          pop = 1'b1;
          unique case (parse_q)
            PS_NORMAL: begin
              if (token_i.cls == CL_ESC) begin
                parse_d     = PS_ESC;
                argc_d      = '0;
                emit        = 1'b1;
                emit_r.last = 1'b1;
              end else if (token_i.cls == CL_LF) begin
                emit             = 1'b1;
                emit_r.op        = OP_CLR_EOL;
                emit_r.cell_row  = cur_row_q;
                emit_r.cell_col  = cur_col_q;
                emit_r.char_code = ChSpace;
                emit_r.attr_out  = attr_q;
                emit_r.last      = !nl_scroll;
                cur_col_d        = '0;
                cur_row_d        = nl_scroll ? cur_row_q : cur_row_q + RowW'(1);
                tab_n_d          = '0;
                if (nl_scroll) begin
                  state_d = ST_SCR;
                end
              end else if (token_i.cls == CL_TAB) begin
                rem_d   = '0;
                step_d  = 3'(ColW - 1);
                state_d = ST_TMOD;
              end else begin
                emit             = 1'b1;
                emit_r.op        = OP_WRITE;
                emit_r.cell_row  = cur_row_q;
                emit_r.cell_col  = cur_col_q;
                emit_r.char_code = token_i.code;
                emit_r.attr_out  = attr_q;
                emit_r.last      = !pc_scroll;
                cur_row_d        = pc_row;
                cur_col_d        = pc_col;
                tab_n_d          = '0;
                if (pc_scroll) begin
                  state_d = ST_SCR;
                end
              end
            end
            PS_ESC: begin
              parse_d     = (token_i.cls == CL_LBRACK) ? PS_BRACKET : PS_NORMAL;
              argc_d      = '0;
              emit        = 1'b1;
              emit_r.last = 1'b1;
            end
            PS_BRACKET: begin
              if (token_i.cls == CL_DIGIT) begin
                wa_en       = 1'b1;
                wa_val      = ArgW'(token_i.code[3:0]);
                argc_d      = CntW'(1);
                parse_d     = PS_ARG;
                emit        = 1'b1;
                emit_r.last = 1'b1;
              end else if (token_i.cls == CL_SEMI) begin
                wa_en       = 1'b1;
                wa_val      = ArgW'(1);
                wb_en       = 1'b1;
                argc_d      = CntW'(2);
                parse_d     = PS_ARG;
                emit        = 1'b1;
                emit_r.last = 1'b1;
              end else begin
                cmd_d   = token_i.code;
                state_d = ST_CMD;
              end
            end
            PS_ARG: begin
              if (token_i.cls == CL_DIGIT) begin
                if (argc_q != '0 && argc_q <= CntW'(MAX_ARGS)) begin
                  wa_en  = 1'b1;
                  wa_idx = argc_m1[IdxW-1:0];
                  wa_val = dig_sat;
                end
                emit        = 1'b1;
                emit_r.last = 1'b1;
              end else if (token_i.cls == CL_SEMI) begin
                if (argc_q < CntW'(MAX_ARGS)) begin
                  wa_en  = 1'b1;
                  wa_idx = argc_q[IdxW-1:0];
                end
                if (argc_q <= CntW'(MAX_ARGS)) begin
                  argc_d = argc_q + CntW'(1);
                end
                emit        = 1'b1;
                emit_r.last = 1'b1;
              end else begin
                cmd_d   = token_i.code;
                state_d = ST_CMD;
              end
            end
          endcase
        end
      end
      ST_TMOD: begin
        rem_d = rem_new;
        if (step_q == 3'd0) begin
          tab_n_d = tab_eff - {1'b0, rem_new};
          state_d = ST_TAB;
        end else begin
          step_d = step_q - 3'd1;
        end
      end
      ST_TAB: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_r.op        = OP_WRITE;
          emit_r.cell_row  = cur_row_q;
          emit_r.cell_col  = cur_col_q;
          emit_r.char_code = ChSpace;
          emit_r.attr_out  = attr_q;
          emit_r.last      = !pc_scroll && (tab_n_q == 5'd1);
          cur_row_d        = pc_row;
          cur_col_d        = pc_col;
          tab_n_d          = tab_n_q - 5'd1;
          if (pc_scroll) begin
            state_d = ST_SCR;
          end else if (tab_n_q == 5'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCR: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_r.op        = OP_SCROLL;
          emit_r.cell_row  = RowW'(Rows - 1);
          emit_r.char_code = ChSpace;
          emit_r.attr_out  = def_attr_q;
          emit_r.last      = (tab_n_q == '0);
          state_d          = (tab_n_q == '0) ? ST_IDLE : ST_TAB;
        end
      end
      ST_CMD: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_r.last = 1'b1;
          state_d     = ST_IDLE;
          parse_d     = PS_NORMAL;
          argc_d      = '0;
          if (cmd_q == CmdEolK) begin
            emit_r.op        = OP_CLR_EOL;
            emit_r.cell_row  = cur_row_q;
            emit_r.cell_col  = cur_col_q;
            emit_r.char_code = ChSpace;
            emit_r.attr_out  = attr_q;
          end else if (cmd_q == CmdSave) begin
            sav_row_d = cur_row_q;
            sav_col_d = cur_col_q;
          end else if (cmd_q == CmdRest) begin
            cur_row_d = sav_row_q;
            cur_col_d = sav_col_q;
          end else if (cmd_q == CmdUp) begin
            cur_row_d = (a0 > ArgW'(cur_row_q)) ? '0 : cur_row_q - a0[RowW-1:0];
          end else if (cmd_q == CmdDown) begin
            cur_row_d = (sum_r >= (ArgW+1)'(Rows)) ? RowW'(Rows - 1) : sum_r[RowW-1:0];
          end else if (cmd_q == CmdRight) begin
            cur_col_d = (sum_c >= (ArgW+1)'(Cols)) ? ColW'(Cols - 1) : sum_c[ColW-1:0];
          end else if (cmd_q == CmdLeft) begin
            cur_col_d = (a0 > ArgW'(cur_col_q)) ? '0 : cur_col_q - a0[ColW-1:0];
          end else if (cmd_q == CmdSgr) begin
            emit    = 1'b0;
            parse_d = parse_q;
            argc_d  = argc_q;
            sgr_i_d = '0;
            sgr_a_d = attr_q & ~BrightBit;
            state_d = ST_SGR;
          end else if (cmd_q == CmdPosF || cmd_q == CmdPosH) begin
            if (argc_q == CntW'(2)) begin
              emit    = 1'b0;
              parse_d = parse_q;
              argc_d  = argc_q;
              if (a0 == '0) begin
                row_tmp_d = '0;
              end else if (a0 > ArgW'(Rows)) begin
                row_tmp_d = RowW'(Rows - 1);
              end else begin
                row_tmp_d = a0[RowW-1:0] - RowW'(1);
              end
              state_d = ST_CMD2;
            end
          end else if (cmd_q == CmdClrJ) begin
            if (argc_q == CntW'(1) && a0 == ArgW'(2)) begin
              cur_row_d        = '0;
              cur_col_d        = '0;
              emit_r.op        = OP_CLR_SCR;
              emit_r.char_code = ChSpace;
              emit_r.attr_out  = attr_q;
            end
          end
        end
      end
      ST_CMD2: begin
        if (out_free) begin
          cur_row_d = row_tmp_q;
          if (rd_val == '0) begin
            cur_col_d = '0;
          end else if (rd_val > ArgW'(Cols)) begin
            cur_col_d = ColW'(Cols - 1);
          end else begin
            cur_col_d = rd_val[ColW-1:0] - ColW'(1);
          end
          emit        = 1'b1;
          emit_r.last = 1'b1;
          parse_d     = PS_NORMAL;
          argc_d      = '0;
          state_d     = ST_IDLE;
        end
      end
      ST_SGR: begin
        if (sgr_i_q == sgr_n) begin
          if (out_free) begin
            attr_d      = sgr_a_q;
            emit        = 1'b1;
            emit_r.last = 1'b1;
            parse_d     = PS_NORMAL;
            argc_d      = '0;
            state_d     = ST_IDLE;
          end
        end else begin
          sgr_a_d = sgr_next;
          sgr_i_d = sgr_i_q + CntW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    emit_r.cursor_row = cur_row_d;
    emit_r.cursor_col = cur_col_d;
  end

  // control state and registered output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      parse_q     <= PS_NORMAL;
      argc_q      <= '0;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      sav_row_q   <= '0;
      sav_col_q   <= '0;
      attr_q      <= 8'd7;
      def_attr_q  <= 8'd7;
      tab_w_q     <= 5'd8;
      tab_n_q     <= '0;
      step_q      <= '0;
      sgr_i_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      parse_q   <= parse_d;
      argc_q    <= argc_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      sav_row_q <= sav_row_d;
      sav_col_q <= sav_col_d;
      attr_q    <= attr_d;
      tab_n_q   <= tab_n_d;
      step_q    <= step_d;
      sgr_i_q   <= sgr_i_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == RegTabWidth) begin
          tab_w_q <= cfg_data_i[4:0];
        end else begin
          def_attr_q <= cfg_data_i;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    row_tmp_q <= row_tmp_d;
    sgr_a_q   <= sgr_a_d;
    cmd_q     <= cmd_d;
    rem_q     <= rem_d;
    if (emit) begin
      out_q <= emit_r;
    end
    if (wa_en) begin
      args_q[wa_idx] <= wa_val;
    end
    if (wb_en) begin
      args_q[IdxW'(1)] <= '0;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.op         = out_q.op;
  assign out_o.cell_row   = out_q.cell_row;
  assign out_o.cell_col   = out_q.cell_col;
  assign out_o.char_code  = out_q.char_code;
  assign out_o.attr_out   = out_q.attr_out;
  assign out_o.cursor_row = out_q.cursor_row;
  assign out_o.cursor_col = out_q.cursor_col;
  assign out_o.last       = out_q.last;

  `ACEC_ASSERT(a_row_on_screen, cur_row_q < RowW'(Rows), "cursor row off screen")
  `ACEC_ASSERT(a_col_on_screen, cur_col_q < ColW'(Cols), "cursor column off screen")
  `ACEC_ASSERT(a_argc_range, argc_q <= CntW'(MAX_ARGS + 1), "argument count overflow")
  `ACEC_ASSERT_IMPL(a_pop_slot, pop, out_free, "token taken while output stalled")
  `ACEC_ASSERT_IMPL(a_tab_left, state_q == ST_TAB, tab_n_q != '0, "tab with no cells left")

endmodule
`default_nettype wire

/* hw/rtl/ansi_text_console_engine_core.sv */
// Top level of the ANSI text console engine.
//
// channel  dir  signals                                      transfer when
// in_i     in   byte_in                                      valid && ready
// out_o    out  op cell_row cell_col char_code attr_out      valid && ready
//               cursor_row cursor_col last
// cfg      in   cfg_we_i cfg_idx_i cfg_data_i                cfg_we_i high
//
// Bytes enter a QUEUE_DEPTH token queue; the back end drains it one byte at a time.
// Plain bytes, ESC and argument bytes are taken and answered from the idle state.
// Tab: take the byte, remainder steps, then a space per cell (plus scrolls).
// SGR: ST_CMD, then ST_SGR reads one stored argument per cycle; f/H: ST_CMD, ST_CMD2.
// Reset is asynchronous, no clearing pass; a stall holds all but remainder and SGR reads.
`timescale 1ns / 1ps
`default_nettype none
module ansi_text_console_engine_core
  import acec_pkg::*;
#(
  parameter int MAX_ARGS    = MaxArgsDef,
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  acec_in_if.sink    in_i,
  acec_out_if.source out_o
);

  logic   push, pop, full, empty;
  token_t tok_in, tok_out;

  acec_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .token_o (tok_in)
  );

  acec_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (tok_in),
    .pop_i   (pop),
    .token_o (tok_out),
    .full_o  (full),
    .empty_o (empty)
  );

  acec_back #(
    .MAX_ARGS (MAX_ARGS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .empty_i    (empty),
    .token_i    (tok_out),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

/* bench/ansi_text_console_engine_core_tb.sv */
// Self-checking testbench for the ANSI text console engine core.
`timescale 1ns / 1ps
module ansi_text_console_engine_core_tb;
  import acec_pkg::*;

  localparam int          RunLimit   = 1_000_000;
  localparam int          SettleCyc  = 60;
  localparam logic [7:0]  CmdBogus   = 8'h7A;  // z, not a known command
  localparam logic [7:0]  ChBell     = 8'h07;

  typedef enum int {PS_NORMAL, PS_ESC, PS_BRACKET, PS_ARG} parse_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;

  acec_in_if  in_if ();
  acec_out_if out_if ();

  ansi_text_console_engine_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Console state mirror
  logic [7:0] mdl_dflt_attr;
  logic [4:0] mdl_tab_w;
  parse_e     mdl_pstate;
  int         mdl_argc;
  int         mdl_argv [MaxArgsDef];
  int         cur_r, cur_c, save_r, save_c;
  logic [7:0] mdl_attr;
  result_t    byte_ops[$];
  result_t    screen_ops_q[$];

  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Screen operation with the cursor as it stands now
  function automatic void add_op(input op_e op, input int r, input int c,
                                 input int ch, input int a);
    result_t x;
    if (byte_ops.size() >= 24) return;
    x.op = op;
    x.cell_row = r[RowW-1:0];
    x.cell_col = c[ColW-1:0];
    x.char_code = ch[7:0];
    x.attr_out = a[7:0];
    x.cursor_row = cur_r[RowW-1:0];
    x.cursor_col = cur_c[ColW-1:0];
    x.last = 1'b0;
    byte_ops.push_back(x);
  endfunction

  function automatic bit advance_line();
    cur_c = 0;
    cur_r++;
    if (cur_r >= Rows) begin
      cur_r = Rows - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void write_cell(input int ch);
    int r, c;
    bit sc;
    r = cur_r;
    c = cur_c;
    sc = 1'b0;
    cur_c++;
    if (cur_c >= Cols) sc = advance_line();
    add_op(OP_WRITE, r, c, ch, mdl_attr);
    if (sc) add_op(OP_SCROLL, Rows - 1, 0, ChSpace, mdl_dflt_attr);
  endfunction

  function automatic void clamp_cursor(input int r, input int c);
    cur_r = (r < 0) ? 0 : (r >= Rows ? Rows - 1 : r);
    cur_c = (c < 0) ? 0 : (c >= Cols ? Cols - 1 : c);
  endfunction

  function automatic int get_arg(input int i);
    return (i < mdl_argc && i < MaxArgsDef) ? mdl_argv[i] : 0;
  endfunction

  function automatic void open_arg();
    int idx;
    idx = mdl_argc;
    if (mdl_argc <= MaxArgsDef) mdl_argc++;
    mdl_pstate = PS_ARG;
    if (idx < MaxArgsDef) mdl_argv[idx] = 0;
  endfunction

  function automatic void push_digit(input int d);
    int i;
    if (mdl_argc == 0 || mdl_argc > MaxArgsDef) return;
    i = mdl_argc - 1;
    mdl_argv[i] = mdl_argv[i] * 10 + d;
    if (mdl_argv[i] > ArgMax) mdl_argv[i] = ArgMax;
  endfunction

  function automatic void select_graphic();
    logic [7:0] a;
    logic [2:0] vga [8];
    int n, v;
    vga = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
    a = mdl_attr & ~BrightBit;
    n = (mdl_argc < MaxArgsDef) ? mdl_argc : MaxArgsDef;
    for (int i = 0; i < n; i++) begin
      v = mdl_argv[i];
      if (v == 0) a = mdl_dflt_attr;
      else if (v == 1) a |= BrightBit;
      else if (v >= 30 && v <= 37) a = {a[7:3], vga[v-30]};
      else if (v >= 40 && v <= 47) a = {a[7], vga[v-40], a[3:0]};
    end
    mdl_attr = a;
  endfunction

  function automatic void run_command(input logic [7:0] b);
    case (b)
      CmdEolK:  add_op(OP_CLR_EOL, cur_r, cur_c, ChSpace, mdl_attr);
      CmdSave: begin
        save_r = cur_r;
        save_c = cur_c;
      end
      CmdRest: begin
        cur_r = save_r;
        cur_c = save_c;
      end
      CmdUp:    clamp_cursor(cur_r - get_arg(0), cur_c);
      CmdDown:  clamp_cursor(cur_r + get_arg(0), cur_c);
      CmdRight: clamp_cursor(cur_r, cur_c + get_arg(0));
      CmdLeft:  clamp_cursor(cur_r, cur_c - get_arg(0));
      CmdSgr:   select_graphic();
      CmdPosF, CmdPosH: begin
        if (mdl_argc == 2) clamp_cursor(get_arg(0) - 1, get_arg(1) - 1);
      end
      CmdClrJ: begin
        if (mdl_argc == 1 && get_arg(0) == 2) begin
          cur_r = 0;
          cur_c = 0;
          add_op(OP_CLR_SCR, 0, 0, ChSpace, mdl_attr);
        end
      end
      default: ;
    endcase
    mdl_pstate = PS_NORMAL;
    mdl_argc = 0;
  endfunction

  // Expected screen operations for one accepted byte
  function automatic void predict_byte(input logic [7:0] b);
    bit dig;
    int tw, n;
    dig = (b >= ChZero && b <= ChNine);
    byte_ops.delete();
    case (mdl_pstate)
      PS_NORMAL: begin
        if (b == ChEsc) begin
          mdl_pstate = PS_ESC;
          mdl_argc = 0;
        end else if (b == ChLf) begin
          int r, c;
          bit sc;
          r = cur_r;
          c = cur_c;
          sc = advance_line();
          add_op(OP_CLR_EOL, r, c, ChSpace, mdl_attr);
          if (sc) add_op(OP_SCROLL, Rows - 1, 0, ChSpace, mdl_dflt_attr);
        end else if (b == ChTab) begin
          tw = (mdl_tab_w == 0) ? 1 : (mdl_tab_w > 16 ? 16 : int'(mdl_tab_w));
          n = tw - (cur_c % tw);
          repeat (n) write_cell(ChSpace);
        end else begin
          write_cell(b);
        end
      end
      PS_ESC: begin
        mdl_pstate = (b == ChLbrack) ? PS_BRACKET : PS_NORMAL;
        mdl_argc = 0;
      end
      PS_BRACKET: begin
        if (dig) begin
          open_arg();
          push_digit(b - ChZero);
        end else if (b == ChSemi) begin
          open_arg();
          push_digit(1);
          open_arg();
        end else begin
          run_command(b);
        end
      end
      default: begin
        if (dig) push_digit(b - ChZero);
        else if (b == ChSemi) open_arg();
        else run_command(b);
      end
    endcase
    if (byte_ops.size() == 0) add_op(OP_CURSOR, 0, 0, 0, 0);
    byte_ops[byte_ops.size()-1].last = 1'b1;
    foreach (byte_ops[i]) screen_ops_q.push_back(byte_ops[i]);
  endfunction

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Output side: random stall and comparison of each transfer
  always @(posedge clk_i) begin
    result_t want;
    if (out_if.valid && out_if.ready) begin
      if (screen_ops_q.size() == 0) begin
        report($sformatf("unexpected result op %0d", out_if.op));
      end else begin
        want = screen_ops_q.pop_front();
        check_field("op", out_if.op, want.op);
        check_field("cell_row", out_if.cell_row, want.cell_row);
        check_field("cell_col", out_if.cell_col, want.cell_col);
        check_field("char_code", out_if.char_code, want.char_code);
        check_field("attr_out", out_if.attr_out, want.attr_out);
        check_field("cursor_row", out_if.cursor_row, want.cursor_row);
        check_field("cursor_col", out_if.cursor_col, want.cursor_col);
        check_field("last", out_if.last, want.last);
      end
    end
    out_if.ready <= rst_ni && ($urandom_range(99) >= rx_stall_pct);
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > RunLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < tx_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.byte_in <= b;
    do @(posedge clk_i); while (!in_if.ready);
    predict_byte(b);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (screen_ops_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegDefAttr) mdl_dflt_attr = val;
    else mdl_tab_w = val[4:0];
  endtask

  task automatic test_plain_and_control();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(ChBell);
    send_byte(ChTab);
    send_byte(ChLf);
    send_text("\033[25;79H");
    send_text("xyz");
    send_byte(ChLf);
  endtask

  task automatic test_escape_commands();
    send_text("\033[5;10Hs\033[s\033[3A\033[2B\033[9C\033[4D\033[u\033[K");
    send_text("\033[0;1;31;42m*\033[9999999A\033[9999C\033[;7H");
    send_text("\033[1;2;3;4;5;6;7;8;9;10H\033[1;2;3;4;5;6;7;8;34;44m#");
    send_text("\033[z\033x\033\033[2J\033[3J\033[m\033[D");
  endtask

  // Well-formed sequences with random content, with some noise mixed in
  task automatic send_random_sequence();
    logic [7:0] cmds [12];
    int nargs, sel;
    cmds = '{CmdUp, CmdDown, CmdRight, CmdLeft, CmdPosH, CmdPosF, CmdClrJ,
             CmdEolK, CmdSgr, CmdSave, CmdRest, CmdBogus};
    sel = $urandom_range(99);
    if (sel < 35) begin
      send_byte(ChEsc);
      send_byte(($urandom_range(19) == 0) ? 8'($urandom) : ChLbrack);
      nargs = ($urandom_range(9) == 0) ? $urandom_range(11) : $urandom_range(3);
      for (int i = 0; i < nargs; i++) begin
        if (i > 0) send_byte(ChSemi);
        case ($urandom_range(3))
          0: ;
          1: send_byte(8'(ChZero + $urandom_range(9)));
          2: send_text($sformatf("%0d", $urandom_range(99)));
          default: send_text($sformatf("%0d", $urandom_range(999999)));
        endcase
      end
      if ($urandom_range(3) == 0) send_byte(8'($urandom));
      else send_byte(cmds[$urandom_range(11)]);
    end else if (sel < 45) begin
      send_byte(ChLf);
    end else if (sel < 55) begin
      send_byte(ChTab);
    end else if (sel < 65) begin
      send_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(12, 1)) send_byte(8'($urandom_range(126, 32)));
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int start;
    start = sent;
    while (sent - start < n_items) begin
      send_random_sequence();
    end
  endtask

  initial begin
    logic [7:0] attrs [4];
    logic [7:0] tabs [4];
    int gaps [4];
    int stalls [4];
    attrs = '{8'h00, 8'hFF, 8'h1E, 8'h5A};
    tabs = '{8'd1, 8'd16, 8'd0, 8'hFF};
    gaps = '{0, 68, 0, 30};
    stalls = '{0, 0, 68, 30};
    in_if.valid <= 1'b0;
    in_if.byte_in <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= RegDefAttr;
    cfg_data_i <= '0;
    mdl_dflt_attr = 8'd7;
    mdl_tab_w = 5'd8;
    mdl_pstate = PS_NORMAL;
    mdl_argc = 0;
    cur_r = 0;
    cur_c = 0;
    save_r = 0;
    save_c = 0;
    mdl_attr = 8'd7;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_plain_and_control();
    test_escape_commands();
    wait_idle();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(RegDefAttr, attrs[ph]);
      write_reg(RegTabWidth, tabs[ph]);
      tx_gap_pct = gaps[ph];
      rx_stall_pct = stalls[ph];
      test_random_traffic(80);
      wait_idle();
    end
    write_reg(RegTabWidth, 8'd8);

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* ansi_text_console_engine_core.f */
+incdir+hw/rtl
hw/rtl/acec_pkg.sv
hw/rtl/acec_stream_if.sv
hw/rtl/acec_front.sv
hw/rtl/acec_fifo.sv
hw/rtl/acec_back.sv
hw/rtl/ansi_text_console_engine_core.sv
bench/ansi_text_console_engine_core_tb.sv
